/* rtl/mm_pkg.sv */
// Shared types, constants and helpers for the matrix multiplier.
package mm_pkg;

   localparam int MAX_DIM    = 8;
   localparam int DATA_WIDTH = 16;
   localparam int DIM_W      = 3;
   localparam int SIZE_W     = 4;
   localparam int ADDR_W     = 2 * DIM_W;
   localparam int DEPTH      = MAX_DIM * MAX_DIM;
   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int ACC_W      = 40;

   localparam logic [1:0] FUNC_LOAD_A = 2'd0;
   localparam logic [1:0] FUNC_LOAD_B = 2'd1;
   localparam logic [1:0] FUNC_START  = 2'd2;

   localparam logic [1:0] CSR_A_ROWS = 2'd0;
   localparam logic [1:0] CSR_A_COLS = 2'd1;
   localparam logic [1:0] CSR_B_ROWS = 2'd2;
   localparam logic [1:0] CSR_B_COLS = 2'd3;

   typedef struct packed {
      logic [1:0]                   func;
      logic [DIM_W-1:0]             elem_row;
      logic [DIM_W-1:0]             elem_col;
      logic signed [DATA_WIDTH-1:0] elem_value;
   } req_type;

   typedef struct packed {
      logic [DIM_W-1:0]        out_row;
      logic [DIM_W-1:0]        out_col;
      logic signed [ACC_W-1:0] out_value;
      logic                    is_last;
      logic                    size_error;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctrl_type;

   // size 0 acts as 1, sizes above the array act as the array size
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (v == '0)
         r = SIZE_W'(1);
      else if (v > SIZE_W'(MAX_DIM))
         r = SIZE_W'(MAX_DIM);
      else
         r = v;
      return r;
   endfunction

endpackage

/* rtl/matrix_multiply.sv */
// Top level: element stores, multiply sequencer, result register.
//
// Load items (A or B element) are taken one per cycle whenever the block is idle
// and are written straight into two 64-entry RAMs addressed {row, col}; loads
// outside the configured size are dropped. A start item computes A*B entry by
// entry in row-major order: each entry reads one A/B pair per cycle from the
// RAMs, one for each of the a_cols terms, then waits for the read, multiply and
// accumulate stages, and is placed in the result register once that register
// is free, that is, while no earlier result still waits on rsp_ready. A size
// mismatch gives one error item. New items are taken while a finished result
// still waits.
module matrix_multiply (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mm_pkg::req_type               req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mm_pkg::rsp_type               rsp_data,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [mm_pkg::SIZE_W-1:0]     csr_wdata
);
   import mm_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [SIZE_W-1:0] a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   logic [SIZE_W-1:0] ar, ac, br, bc;
   logic [1:0]        state_ff, state_in;
   logic [DIM_W-1:0]  i_ff, j_ff, k_ff, i_in, j_in, k_in;
   logic              err_ff, err_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept, out_free, last_k, last_i, last_j;
   logic              a_we, b_we;
   logic [DATA_WIDTH-1:0] a_rd, b_rd;
   logic [ACC_W-1:0]  acc;
   logic              mac_done;
   mac_ctrl_type      issue;

   assign ar = eff_size(a_rows_ff);
   assign ac = eff_size(a_cols_ff);
   assign br = eff_size(b_rows_ff);
   assign bc = eff_size(b_cols_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   assign last_k = ({1'b0, k_ff} == ac - SIZE_W'(1));
   assign last_j = ({1'b0, j_ff} == bc - SIZE_W'(1));
   assign last_i = ({1'b0, i_ff} == ar - SIZE_W'(1));

   assign a_we = accept && req_data.func == FUNC_LOAD_A &&
                 {1'b0, req_data.elem_row} < ar && {1'b0, req_data.elem_col} < ac;
   assign b_we = accept && req_data.func == FUNC_LOAD_B &&
                 {1'b0, req_data.elem_row} < br && {1'b0, req_data.elem_col} < bc;

   mm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr ({req_data.elem_row, req_data.elem_col}),
      .wr_data (req_data.elem_value),
      .rd_addr ({i_ff, k_ff}),
      .rd_data (a_rd)
   );

   mm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_b_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr ({req_data.elem_row, req_data.elem_col}),
      .wr_data (req_data.elem_value),
      .rd_addr ({k_ff, j_ff}),
      .rd_data (b_rd)
   );

   always_comb begin
      issue.valid = (state_ff == ST_RUN);
      issue.first = (k_ff == '0);
      issue.last  = last_k;
   end

   mm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .a_data (a_rd),
      .b_data (b_rd),
      .acc    (acc),
      .done   (mac_done)
   );

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.func == FUNC_START) begin
               i_in = '0;
               j_in = '0;
               k_in = '0;
               if (ac != br) begin
                  err_in   = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (last_k) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + DIM_W'(1);
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (err_ff) begin
                  rsp_data_in = '{out_row: '0, out_col: '0, out_value: '0,
                                  is_last: 1'b1, size_error: 1'b1};
                  err_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  rsp_data_in = '{out_row: i_ff, out_col: j_ff, out_value: acc,
                                  is_last: last_i & last_j, size_error: 1'b0};
                  if (last_j) begin
                     j_in = '0;
                     i_in = i_ff + DIM_W'(1);
                  end else begin
                     j_in = j_ff + DIM_W'(1);
                  end
                  state_in = (last_i & last_j) ? ST_IDLE : ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         a_rows_ff    <= SIZE_W'(MAX_DIM);
         a_cols_ff    <= SIZE_W'(MAX_DIM);
         b_rows_ff    <= SIZE_W'(MAX_DIM);
         b_cols_ff    <= SIZE_W'(MAX_DIM);
      end else begin
         state_ff     <= state_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         if (csr_we) begin
            case (csr_index)
               CSR_A_ROWS: a_rows_ff <= csr_wdata;
               CSR_A_COLS: a_cols_ff <= csr_wdata;
               CSR_B_ROWS: b_rows_ff <= csr_wdata;
               CSR_B_COLS: b_cols_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

/* rtl/mm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/mm_mac.sv */
// Multiply-accumulate pipeline: aligns control with RAM data, multiplies, sums.
module mm_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mm_pkg::mac_ctrl_type                  issue,
   input  logic signed [mm_pkg::DATA_WIDTH-1:0]  a_data,
   input  logic signed [mm_pkg::DATA_WIDTH-1:0]  b_data,
   output logic signed [mm_pkg::ACC_W-1:0]       acc,
   output logic                                  done
);
   import mm_pkg::*;

   mac_ctrl_type              ctl1_ff, ctl2_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   prod_ext;

   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (ctl2_ff.valid) begin
         acc_in = ctl2_ff.first ? prod_ext : acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         done    <= 1'b0;
      end else begin
         ctl1_ff <= issue;
         ctl2_ff <= ctl1_ff;
         done    <= ctl2_ff.valid & ctl2_ff.last;
      end
      prod_ff <= a_data * b_data;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;
endmodule

/* rtl/mm_checker.sv */
// Port-level checks for the matrix multiplier, bound to the top level.
module mm_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input mm_pkg::rsp_type           rsp_data
);
   import mm_pkg::*;

   // a result that is not taken holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.size_error |-> rsp_data.is_last)
      else $error("error item without last marker");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.size_error |->
         rsp_data.out_row == '0 && rsp_data.out_col == '0 && rsp_data.out_value == '0)
      else $error("error item with nonzero fields");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
